>>> rtl/olist_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and codes for the ordered list engine.
// ----------------------------------------------------------------------------
package olist_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_INS_HEAD = 2'd0,
    OP_INS_TAIL = 2'd1,
    OP_DELETE   = 2'd2,
    OP_SEARCH   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic    accept;      // request transaction taken this cycle
    logic    ins_head;    // write value before head
    logic    ins_tail;    // write value after tail
    logic    scan_step;   // issue next compare read
    logic    found_pos;   // latch match position (search)
    logic    shift_start; // begin closing the gap after the match
    logic    shift_step;  // move one entry toward the head
    logic    del_done;    // drop one from the count
    logic    out_load;    // load result register
    status_t out_status;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic hit;        // read data matches key
    logic miss;       // scan ran past the last entry
    logic shift_done; // no read pending and nothing left to move
    logic out_busy;   // result register still held by the sink
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/olist_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olist_ifs
// Request and result channels of the ordered list engine.
// ----------------------------------------------------------------------------
interface olist_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface olist_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] position;
  logic [4:0] count;

  modport source (output valid, output status, output position, output count, input ready);
  modport sink   (input valid, input status, input position, input count, output ready);
endinterface

`default_nettype wire

>>> rtl/ordered_list_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed 32-bit values with insert at head or tail,
// delete of the first match and search for the first match.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                          transaction
//  -------  ---  -------------------------------  ------------------------
//  in_ch    in   op[1:0], value[31:0] signed      request, valid & ready
//  out_ch   out  status[1:0], position[3:0],      one result per request,
//                count[4:0]                       valid & ready
//
//  Steps: an insert is accepted, then its result is loaded. Search reads
//    entries in order from the head and stops at the first match or past the
//    last entry. Delete scans to the match, then moves every later entry one
//    slot toward the head. The entry memory has one read port, so the walk
//    handles one entry per cycle.
//  Reset (rst, synchronous): list empty, no result pending. No clearing pass.
//  Stalls: a request is taken while the previous result waits in the output
//    register; the new result waits until that one is taken.
//
module ordered_list_engine #(
  parameter int CAPACITY = 16
) (
  input wire          clk,
  input wire          rst,
  olist_req_if.sink   in_ch,
  olist_rsp_if.source out_ch
);

  olist_pkg::cmd_t cmd;
  olist_pkg::sts_t sts;

  // sequencer
  olist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, compare and result register
  olist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_value     (in_ch.value),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_status   (out_ch.status),
    .out_position (out_ch.position),
    .out_count    (out_ch.count)
  );

  // Checks

  // one request at a time: after a transaction the engine is busy
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while a request was in progress");

  // an empty-list result reports no entries and no position
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == olist_pkg::ST_EMPTY)
      |-> (out_ch.count == 5'd0 && out_ch.position == 4'd0))
    else $error("empty status with nonzero count or position");

  // position is only reported on success
  a_pos_on_ok: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != olist_pkg::ST_OK) |-> out_ch.position == 4'd0)
    else $error("position set on a failed request");

  // count flags are exclusive
  a_flags: assert property (@(posedge clk) disable iff (rst)
    !(sts.empty && sts.full))
    else $error("list both empty and full");

endmodule

`default_nettype wire

>>> rtl/olist_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olist_ctrl
// Sequencer for one request: decode, scan, gap close, result.
// ----------------------------------------------------------------------------
module olist_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  input  wire  [1:0]       in_op,
  output logic             in_ready,
  input  olist_pkg::sts_t  sts,
  output olist_pkg::cmd_t  cmd
);

  olist_pkg::state_t  state, state_next;
  olist_pkg::op_t     op, op_next;
  olist_pkg::status_t res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= olist_pkg::S_IDLE;
      op    <= olist_pkg::OP_INS_HEAD;
      res   <= olist_pkg::ST_OK;
    end else begin
      state <= state_next;
      op    <= op_next;
      res   <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    res_next   = res;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.out_status = res;
    unique case (state)
      olist_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          op_next    = olist_pkg::op_t'(in_op);
          unique case (olist_pkg::op_t'(in_op))
            olist_pkg::OP_INS_HEAD, olist_pkg::OP_INS_TAIL: begin
              state_next = olist_pkg::S_RESP;
              if (sts.full) begin
                res_next = olist_pkg::ST_FULL;
              end else begin
                res_next     = olist_pkg::ST_OK;
                cmd.ins_head = (olist_pkg::op_t'(in_op) == olist_pkg::OP_INS_HEAD);
                cmd.ins_tail = (olist_pkg::op_t'(in_op) == olist_pkg::OP_INS_TAIL);
              end
            end
            default: begin
              if (sts.empty) begin
                res_next   = olist_pkg::ST_EMPTY;
                state_next = olist_pkg::S_RESP;
              end else begin
                state_next = olist_pkg::S_SCAN;
              end
            end
          endcase
        end
      end
      olist_pkg::S_SCAN: begin
        if (sts.hit) begin
          res_next = olist_pkg::ST_OK;
          if (op == olist_pkg::OP_SEARCH) begin
            cmd.found_pos = 1'b1;
            state_next    = olist_pkg::S_RESP;
          end else begin
            cmd.shift_start = 1'b1;
            state_next      = olist_pkg::S_SHIFT;
          end
        end else if (sts.miss) begin
          res_next   = olist_pkg::ST_NOT_FOUND;
          state_next = olist_pkg::S_RESP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      olist_pkg::S_SHIFT: begin
        if (sts.shift_done) begin
          cmd.del_done = 1'b1;
          state_next   = olist_pkg::S_RESP;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      olist_pkg::S_RESP: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = olist_pkg::S_IDLE;
        end
      end
      default: state_next = olist_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/olist_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olist_dp
// Entry memory kept as a ring from a head pointer, count, scan counter,
// key compare and result register.
// ----------------------------------------------------------------------------
module olist_dp #(
  parameter int CAPACITY = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  olist_pkg::cmd_t    cmd,
  output olist_pkg::sts_t    sts,
  input  wire  signed [31:0] in_value,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [1:0]         out_status,
  output logic [3:0]         out_position,
  output logic [4:0]         out_count
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW:0]   CAP_X  = (IW + 1)'(CAPACITY);
  localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rd_data;
  logic [31:0]   key;
  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;  // next logical index to read
  logic [CW-1:0] rd_idx;    // logical index of rd_data
  logic          rd_vld;
  logic [CW-1:0] pos;

  logic          issue;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [IW-1:0] head_dec;
  logic [CW-1:0] rd_prev;
  logic [CW+4:0] count_ext;
  logic [CW+3:0] pos_ext;

  // logical index -> slot, wrapping at CAPACITY
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [IW-1:0] i);
    logic [IW:0] s;
    s = {1'b0, h} + {1'b0, i};
    if (s >= CAP_X) s = s - CAP_X;
    return s[IW-1:0];
  endfunction

  assign head_dec = (head == '0) ? LAST_I : head - IW'(1);
  assign rd_prev  = rd_idx - CW'(1);
  assign issue    = (cmd.scan_step || cmd.shift_step) && (scan_idx < count);
  assign rd_addr  = phys(head, scan_idx[IW-1:0]);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head_dec;
    wr_data = in_value;
    if (cmd.ins_head) begin
      wr_en = 1'b1;
    end else if (cmd.ins_tail) begin
      wr_en   = 1'b1;
      wr_addr = phys(head, count[IW-1:0]);
    end else if (cmd.shift_step && rd_vld) begin
      wr_en   = 1'b1;
      wr_addr = phys(head, rd_prev[IW-1:0]);
      wr_data = rd_data;
    end
  end

  // entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      rd_vld    <= 1'b0;
      scan_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ins_head) head <= head_dec;
      if (cmd.ins_head || cmd.ins_tail) count <= count + CW'(1);
      else if (cmd.del_done) count <= count - CW'(1);

      if (cmd.accept) begin
        scan_idx <= '0;
        rd_vld   <= 1'b0;
      end else if (cmd.shift_start) begin
        scan_idx <= rd_idx + CW'(1);
        rd_vld   <= 1'b0;
      end else begin
        rd_vld <= issue;
        if (issue) scan_idx <= scan_idx + CW'(1);
      end

      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key <= in_value;
      pos <= '0;
    end else if (cmd.found_pos) begin
      pos <= rd_idx;
    end
    if (issue) rd_idx <= scan_idx;
  end

  assign count_ext = {5'b0, count};
  assign pos_ext   = {4'b0, pos};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status   <= cmd.out_status;
      out_position <= (cmd.out_status == olist_pkg::ST_OK) ? pos_ext[3:0] : 4'd0;
      out_count    <= count_ext[4:0];
    end
  end

  always_comb begin
    sts            = '0;
    sts.empty      = (count == '0);
    sts.full       = (count == CAP_C);
    sts.hit        = rd_vld && (rd_data == key);
    sts.miss       = !rd_vld && (scan_idx >= count);
    sts.shift_done = !rd_vld && (scan_idx >= count);
    sts.out_busy   = out_valid && !out_ready;
  end

endmodule

`default_nettype wire
